FILE: sv/tdr_pkg.sv
package tdr_pkg;

	localparam int DEF_MAX_STATES  = 16;
	localparam int DEF_MAX_SYMBOLS = 8;

	localparam int KIND_W   = 3;
	localparam int LABEL_W  = 8;
	localparam int CFG_W    = 5;
	localparam int CFG_IDX_W = 2;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_STATE_LABEL  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SYMBOL_LABEL = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TRANSITION   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ACCEPT_MARK  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SYMBOL       = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_SYMBOLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 2'd2;

	// store write enables
	typedef struct packed {
		logic st_we;
		logic sy_we;
		logic nx_we;
		logic ac_we;
	} wr_t;

	// store read enables
	typedef struct packed {
		logic st_re;
		logic sy_re;
		logic nx_re;
		logic ac_re;
	} rd_t;

endpackage

FILE: sv/table_driven_dfa_runner.sv
// state, symbol label and accepting mark loads are written directly; a transition load
// first has its next-state index reduced in one registered reciprocal-multiply step
// per symbol: labels are scanned to a match (all of them when unknown), then the next
// state is looked up; a string's first symbol adds the start-state reduction, the last
// a final result; one item at a time, input stalls until the item ends; out_stall holds it
// reset: control, config (1 symbol, start state 0) and accepting marks clear at once
module table_driven_dfa_runner #(
	parameter int MAX_STATES  = tdr_pkg::DEF_MAX_STATES,
	parameter int MAX_SYMBOLS = tdr_pkg::DEF_MAX_SYMBOLS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tdr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tdr_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [tdr_pkg::KIND_W-1:0]       kind,
	input  logic [3:0]                       row,
	input  logic [2:0]                       column,
	input  logic [tdr_pkg::LABEL_W-1:0]      data,
	input  logic                             last,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tdr_pkg::LABEL_W-1:0]      path_state,
	output logic                             done_res,
	output logic                             accepted,
	output logic                             bad_symbol
);

	localparam int SW = $clog2(MAX_STATES);
	localparam int YW = $clog2(MAX_SYMBOLS);
	localparam int JW = $clog2(MAX_SYMBOLS + 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_MOD   = 8'b00000010,
		S_SCAN  = 8'b00000100,
		S_MATCH = 8'b00001000,
		S_LOOK  = 8'b00010000,
		S_EMIT  = 8'b00100000,
		S_FIN   = 8'b01000000,
		S_EMITF = 8'b10000000
	} state_t;

	state_t                      state_q;
	logic [3:0]                  num_symbols_q;
	logic [3:0]                  start_state_q;
	logic                        in_string_q;
	logic [SW-1:0]               cur_q;
	logic [YW-1:0]               sym_q;
	logic [JW-1:0]               j_q;
	logic                        bad_q;
	logic                        last_q;
	logic                        for_load_q;
	logic [SW-1:0]               row_q;
	logic [YW-1:0]               col_q;
	logic [tdr_pkg::LABEL_W-1:0] data_q;

	logic                        out_valid_q;
	logic [tdr_pkg::LABEL_W-1:0] path_state_q;
	logic                        done_res_q;
	logic                        accepted_q;
	logic                        bad_symbol_q;

	logic                        in_xfer;
	logic                        row_ok;
	logic                        col_ok;
	logic                        out_free;
	logic                        emit;
	logic [7:0]                  limit;
	logic                        scan_more;
	logic                        rem_start;
	logic [tdr_pkg::LABEL_W-1:0] rem_din;
	logic [tdr_pkg::LABEL_W-1:0] rem;
	logic                        rem_done;

	tdr_pkg::wr_t                wr;
	tdr_pkg::rd_t                rd;
	logic [SW-1:0]               wr_row;
	logic [YW-1:0]               wr_col;
	logic [tdr_pkg::LABEL_W-1:0] wr_data;
	logic [YW-1:0]               rd_sym;
	logic [tdr_pkg::LABEL_W-1:0] st_label;
	logic [tdr_pkg::LABEL_W-1:0] sy_label;
	logic [SW-1:0]               nx_state;
	logic                        acc;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign row_ok   = (9'(row) < 9'(MAX_STATES));
	assign col_ok   = (7'(column) < 7'(MAX_SYMBOLS));
	assign out_free = !out_valid_q || !out_stall;
	assign emit     = ((state_q == S_EMIT) || (state_q == S_EMITF)) && out_free;

	// labels searched: num_symbols, capped at the store depth
	assign limit     = (8'(num_symbols_q) > 8'(MAX_SYMBOLS)) ? 8'(MAX_SYMBOLS)
	                                                        : 8'(num_symbols_q);
	assign scan_more = (8'(j_q) < limit);

	// remainder unit: next-state index of a transition load, or start state
	assign rem_start = in_xfer && (((kind == tdr_pkg::KIND_TRANSITION) && row_ok && col_ok)
	                   || ((kind == tdr_pkg::KIND_SYMBOL) && !in_string_q));
	assign rem_din   = (kind == tdr_pkg::KIND_TRANSITION) ? data
	                                                      : tdr_pkg::LABEL_W'(start_state_q);

	tdr_rem #(
		.MAX_STATES(MAX_STATES)
	) u_rem (
		.clk   (clk),
		.arst_n(arst_n),
		.start (rem_start),
		.din   (rem_din),
		.done  (rem_done),
		.rem   (rem)
	);

	always_comb begin
		wr.st_we = in_xfer && (kind == tdr_pkg::KIND_STATE_LABEL) && row_ok;
		wr.sy_we = in_xfer && (kind == tdr_pkg::KIND_SYMBOL_LABEL) && col_ok;
		wr.ac_we = in_xfer && (kind == tdr_pkg::KIND_ACCEPT_MARK) && row_ok;
		wr.nx_we = (state_q == S_MOD) && rem_done && for_load_q;
		rd.sy_re = (state_q == S_SCAN) && scan_more;
		rd.st_re = (state_q == S_LOOK) || (state_q == S_FIN);
		rd.nx_re = (state_q == S_LOOK);
		rd.ac_re = (state_q == S_FIN);
	end

	assign wr_row  = (state_q == S_MOD) ? row_q : SW'(row);
	assign wr_col  = (state_q == S_MOD) ? col_q : YW'(column);
	assign wr_data = (state_q == S_MOD) ? rem : data;
	assign rd_sym  = (state_q == S_SCAN) ? j_q[YW-1:0] : sym_q;

	tdr_store #(
		.MAX_STATES (MAX_STATES),
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.wr_row  (wr_row),
		.wr_col  (wr_col),
		.wr_data (wr_data),
		.rd      (rd),
		.rd_state(cur_q),
		.rd_sym  (rd_sym),
		.st_label(st_label),
		.sy_label(sy_label),
		.nx_state(nx_state),
		.acc     (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_symbols_q <= 4'd1;
			start_state_q <= 4'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				tdr_pkg::CFG_NUM_SYMBOLS: num_symbols_q <= cfg_data[3:0];
				tdr_pkg::CFG_START_STATE: start_state_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_string_q <= 1'b0;
			cur_q       <= '0;
			j_q         <= '0;
			bad_q       <= 1'b0;
			for_load_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (rem_start) begin
						for_load_q <= (kind == tdr_pkg::KIND_TRANSITION);
						state_q    <= S_MOD;
					end else if (in_xfer && (kind == tdr_pkg::KIND_SYMBOL)) begin
						state_q <= S_SCAN;
					end
					j_q   <= '0;
					bad_q <= 1'b0;
				end
				S_MOD: begin
					if (rem_done) begin
						if (for_load_q) begin
							state_q <= S_IDLE;
						end else begin
							cur_q       <= rem[SW-1:0];
							in_string_q <= 1'b1;
							state_q     <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_more) begin
						state_q <= S_MATCH;
					end else begin
						bad_q   <= 1'b1;
						state_q <= S_LOOK;
					end
				end
				S_MATCH: begin
					if (sy_label == data_q) begin
						state_q <= S_LOOK;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_LOOK: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (bad_q) begin
							in_string_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							cur_q   <= nx_state;
							state_q <= last_q ? S_FIN : S_IDLE;
						end
					end
				end
				S_FIN: begin
					state_q <= S_EMITF;
				end
				S_EMITF: begin
					if (out_free) begin
						in_string_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item fields held while the item is worked on
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			row_q  <= SW'(row);
			col_q  <= YW'(column);
			data_q <= data;
			last_q <= last;
		end
		if ((state_q == S_MATCH) && (sy_label == data_q)) begin
			sym_q <= j_q[YW-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			path_state_q <= st_label;
			if (state_q == S_EMITF) begin
				done_res_q   <= 1'b1;
				accepted_q   <= acc;
				bad_symbol_q <= 1'b0;
			end else begin
				done_res_q   <= bad_q;
				accepted_q   <= 1'b0;
				bad_symbol_q <= bad_q;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign path_state = path_state_q;
	assign done_res   = done_res_q;
	assign accepted   = accepted_q;
	assign bad_symbol = bad_symbol_q;

	a_bad_ends_string: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bad_symbol_q |-> done_res_q)
		else $error("bad symbol result without done");

	a_acc_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !done_res_q |-> !accepted_q)
		else $error("accept flag on a path result");

	a_rem_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> in_stall)
		else $error("input taken while remainder result pending");

	a_final_clears_string: assert property (@(posedge clk) disable iff (!arst_n)
		emit && (state_q == S_EMITF) |=> !in_string_q)
		else $error("string still open after final result");

endmodule

FILE: sv/tdr_store.sv
module tdr_store #(
	parameter int MAX_STATES  = tdr_pkg::DEF_MAX_STATES,
	parameter int MAX_SYMBOLS = tdr_pkg::DEF_MAX_SYMBOLS,
	localparam int SW = $clog2(MAX_STATES),
	localparam int YW = $clog2(MAX_SYMBOLS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tdr_pkg::wr_t               wr,
	input  logic [SW-1:0]              wr_row,
	input  logic [YW-1:0]              wr_col,
	input  logic [tdr_pkg::LABEL_W-1:0] wr_data,
	input  tdr_pkg::rd_t               rd,
	input  logic [SW-1:0]              rd_state,
	input  logic [YW-1:0]              rd_sym,
	output logic [tdr_pkg::LABEL_W-1:0] st_label,
	output logic [tdr_pkg::LABEL_W-1:0] sy_label,
	output logic [SW-1:0]              nx_state,
	output logic                       acc
);

	localparam int NX_DEPTH = 2 ** (SW + YW);

	logic [tdr_pkg::LABEL_W-1:0] st_mem [MAX_STATES];
	logic [tdr_pkg::LABEL_W-1:0] sy_mem [MAX_SYMBOLS];
	// transition table addressed as {state, symbol}
	logic [SW-1:0]               nx_mem [NX_DEPTH];
	logic [MAX_STATES-1:0]       acc_flags_q;

	always_ff @(posedge clk) begin
		if (wr.st_we) begin
			st_mem[wr_row] <= wr_data;
		end
		if (rd.st_re) begin
			st_label <= st_mem[rd_state];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.sy_we) begin
			sy_mem[wr_col] <= wr_data;
		end
		if (rd.sy_re) begin
			sy_label <= sy_mem[rd_sym];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.nx_we) begin
			nx_mem[{wr_row, wr_col}] <= wr_data[SW-1:0];
		end
		if (rd.nx_re) begin
			nx_state <= nx_mem[{rd_state, rd_sym}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_flags_q <= '0;
		end else if (wr.ac_we) begin
			acc_flags_q[wr_row] <= wr_data[0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd.ac_re) begin
			acc <= acc_flags_q[rd_state];
		end
	end

endmodule

FILE: sv/tdr_rem.sv
module tdr_rem #(
	parameter int MAX_STATES = tdr_pkg::DEF_MAX_STATES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tdr_pkg::LABEL_W-1:0] din,
	output logic                        done,
	output logic [tdr_pkg::LABEL_W-1:0] rem
);

	// remainder by reciprocal multiplication, exact for every 8-bit value
	// while the state count stays at or below 256
	localparam int QS    = 2 * tdr_pkg::LABEL_W;
	localparam int RECIP = ((2 ** QS) + MAX_STATES - 1) / MAX_STATES;
	localparam int PW    = QS + tdr_pkg::LABEL_W;

	logic                        done_q;
	logic [tdr_pkg::LABEL_W-1:0] rem_q;
	logic [PW-1:0]               prod;
	logic [tdr_pkg::LABEL_W-1:0] quo;
	logic [PW-1:0]               back;
	logic [tdr_pkg::LABEL_W-1:0] rem_d;

	assign prod  = PW'(din) * PW'(RECIP);
	assign quo   = prod[QS +: tdr_pkg::LABEL_W];
	assign back  = PW'(quo) * PW'(MAX_STATES);
	assign rem_d = tdr_pkg::LABEL_W'(PW'(din) - back);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
